FILE: sv/ssa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// shared types and constants of the session slot allocator
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int LINK_W    = 5;
    localparam int OWNER_W   = 16;
    localparam int SLOT_W    = 4;
    localparam int CFG_W     = 5;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    localparam logic [LINK_W-1:0] LINK_NONE = 5'd31;
    localparam logic [CFG_W-1:0]  MAX_PER_OWNER_RST = 5'd4;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_LIMIT      = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_ACTIVE = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_POP,
        ST_LINK,
        ST_REL_READ,
        ST_REL_PREV,
        ST_REL_NEXT,
        ST_DONE
    } ssa_state_t;

    // one slot entry as stored in the slot memory
    typedef struct packed {
        logic               in_use;
        logic [OWNER_W-1:0] owner;
        logic [LINK_W-1:0]  next;
        logic [LINK_W-1:0]  prev;
    } ssa_entry_t;

    localparam int ENTRY_W = $bits(ssa_entry_t);

    typedef struct packed {
        logic               action;
        logic [OWNER_W-1:0] owner;
        logic [SLOT_W-1:0]  slot;
    } ssa_req_t;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
    } ssa_res_t;

    typedef struct packed {
        logic              we;
        logic [LINK_W-1:0] waddr;
        ssa_entry_t        wdata;
        logic [LINK_W-1:0] raddr;
    } ssa_mem_req_t;

endpackage

FILE: sv/ssa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH  = 27,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ssa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_seq
// request sequencer: list walk and read-modify-write of the slot memory
// ----------------------------------------------------------------------------
module ssa_seq #(
    parameter int SLOTS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ssa_pkg::ssa_req_t          req,
    input  logic [ssa_pkg::CFG_W-1:0]  max_per_owner,
    output ssa_pkg::ssa_res_t          res,
    input  logic                       res_ready,
    output ssa_pkg::ssa_mem_req_t      mem,
    input  ssa_pkg::ssa_entry_t        mem_rdata
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam logic [ssa_pkg::LINK_W-1:0] SLOTS_L = ssa_pkg::LINK_W'(SLOTS);

    ssa_pkg::ssa_state_t state_reg, state_next;

    logic [ADDR_W-1:0]               clr_reg, clr_next;
    logic [ssa_pkg::LINK_W-1:0]      free_top_reg, free_top_next;
    logic [ssa_pkg::LINK_W-1:0]      active_top_reg, active_top_next;
    logic [ssa_pkg::LINK_W-1:0]      count_reg, count_next;
    logic [ssa_pkg::LINK_W-1:0]      steps_reg, steps_next;
    logic [ssa_pkg::LINK_W-1:0]      slot_reg, slot_next;
    logic [ssa_pkg::LINK_W-1:0]      prev_reg, prev_next;
    logic [ssa_pkg::LINK_W-1:0]      next_reg, next_next;
    logic [ssa_pkg::OWNER_W-1:0]     owner_reg, owner_next;
    logic [ssa_pkg::STAT_W-1:0]      status_reg, status_next;
    logic [ssa_pkg::SLOT_W-1:0]      grant_reg, grant_next;

    logic [ssa_pkg::LINK_W-1:0]      step_inc;
    logic [ssa_pkg::LINK_W-1:0]      match_inc;

    function automatic logic in_pool(input logic [ssa_pkg::LINK_W-1:0] idx);
        return idx < SLOTS_L;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ssa_pkg::ST_INIT;
            clr_reg        <= '0;
            free_top_reg   <= '0;
            active_top_reg <= ssa_pkg::LINK_NONE;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_top_reg   <= free_top_next;
            active_top_reg <= active_top_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg  <= count_next;
        steps_reg  <= steps_next;
        slot_reg   <= slot_next;
        prev_reg   <= prev_next;
        next_reg   <= next_next;
        owner_reg  <= owner_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
    end

    assign step_inc  = steps_reg + ssa_pkg::LINK_W'(1);
    assign match_inc = (mem_rdata.owner == owner_reg) ? ssa_pkg::LINK_W'(1) : '0;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        free_top_next   = free_top_reg;
        active_top_next = active_top_reg;
        count_next      = count_reg;
        steps_next      = steps_reg;
        slot_next       = slot_reg;
        prev_next       = prev_reg;
        next_next       = next_reg;
        owner_next      = owner_reg;
        status_next     = status_reg;
        grant_next      = grant_reg;
        req_ready       = 1'b0;
        res.valid       = 1'b0;
        res.status      = status_reg;
        res.slot        = grant_reg;
        mem.we          = 1'b0;
        mem.waddr       = '0;
        mem.wdata       = mem_rdata;
        mem.raddr       = '0;

        unique case (state_reg)
            ssa_pkg::ST_INIT: begin
                // lay down the free chain 0,1,2,... one entry a cycle
                mem.we           = 1'b1;
                mem.waddr        = ssa_pkg::LINK_W'(clr_reg);
                mem.wdata.in_use = 1'b0;
                mem.wdata.owner  = '0;
                mem.wdata.prev   = ssa_pkg::LINK_NONE;
                if (clr_reg == ADDR_W'(SLOTS - 1)) begin
                    mem.wdata.next = ssa_pkg::LINK_NONE;
                    state_next     = ssa_pkg::ST_IDLE;
                end else begin
                    mem.wdata.next = ssa_pkg::LINK_W'(clr_reg) + ssa_pkg::LINK_W'(1);
                    clr_next       = clr_reg + ADDR_W'(1);
                end
            end

            ssa_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    owner_next = req.owner;
                    slot_next  = ssa_pkg::LINK_W'(req.slot);
                    count_next = '0;
                    steps_next = '0;
                    grant_next = '0;
                    if (req.action == ssa_pkg::ACT_ALLOC) begin
                        if (in_pool(active_top_reg)) begin
                            mem.raddr  = active_top_reg;
                            state_next = ssa_pkg::ST_WALK;
                        end else begin
                            state_next = ssa_pkg::ST_CHECK;
                        end
                    end else begin
                        if (in_pool(ssa_pkg::LINK_W'(req.slot))) begin
                            mem.raddr  = ssa_pkg::LINK_W'(req.slot);
                            state_next = ssa_pkg::ST_REL_READ;
                        end else begin
                            status_next = ssa_pkg::STATUS_NOT_ACTIVE;
                            state_next  = ssa_pkg::ST_DONE;
                        end
                    end
                end
            end

            ssa_pkg::ST_WALK: begin
                // one active entry per cycle, next address straight from read data
                count_next = count_reg + match_inc;
                steps_next = step_inc;
                if (step_inc < SLOTS_L && in_pool(mem_rdata.next)) begin
                    mem.raddr = mem_rdata.next;
                end else begin
                    state_next = ssa_pkg::ST_CHECK;
                end
            end

            ssa_pkg::ST_CHECK: begin
                if (count_reg >= max_per_owner || !in_pool(free_top_reg)) begin
                    status_next = ssa_pkg::STATUS_LIMIT;
                    state_next  = ssa_pkg::ST_DONE;
                end else begin
                    mem.raddr  = free_top_reg;
                    state_next = ssa_pkg::ST_POP;
                end
            end

            ssa_pkg::ST_POP: begin
                mem.we           = 1'b1;
                mem.waddr        = free_top_reg;
                mem.wdata.in_use = 1'b1;
                mem.wdata.owner  = owner_reg;
                mem.wdata.next   = active_top_reg;
                mem.wdata.prev   = ssa_pkg::LINK_NONE;
                free_top_next    = mem_rdata.next;
                active_top_next  = free_top_reg;
                grant_next       = free_top_reg[ssa_pkg::SLOT_W-1:0];
                prev_next        = free_top_reg;
                next_next        = active_top_reg;
                status_next      = ssa_pkg::STATUS_OK;
                if (in_pool(active_top_reg)) begin
                    mem.raddr  = active_top_reg;
                    state_next = ssa_pkg::ST_LINK;
                end else begin
                    state_next = ssa_pkg::ST_DONE;
                end
            end

            ssa_pkg::ST_LINK: begin
                // old head gets the new slot as its predecessor
                mem.we         = 1'b1;
                mem.waddr      = next_reg;
                mem.wdata.prev = prev_reg;
                state_next     = ssa_pkg::ST_DONE;
            end

            ssa_pkg::ST_REL_READ: begin
                if (!mem_rdata.in_use) begin
                    status_next = ssa_pkg::STATUS_NOT_ACTIVE;
                    state_next  = ssa_pkg::ST_DONE;
                end else begin
                    status_next      = ssa_pkg::STATUS_OK;
                    prev_next        = mem_rdata.prev;
                    next_next        = mem_rdata.next;
                    mem.we           = 1'b1;
                    mem.waddr        = slot_reg;
                    mem.wdata.in_use = 1'b0;
                    mem.wdata.owner  = '0;
                    mem.wdata.next   = free_top_reg;
                    mem.wdata.prev   = ssa_pkg::LINK_NONE;
                    free_top_next    = slot_reg;
                    if (in_pool(mem_rdata.prev)) begin
                        mem.raddr  = mem_rdata.prev;
                        state_next = ssa_pkg::ST_REL_PREV;
                    end else begin
                        active_top_next = mem_rdata.next;
                        if (in_pool(mem_rdata.next)) begin
                            mem.raddr  = mem_rdata.next;
                            state_next = ssa_pkg::ST_REL_NEXT;
                        end else begin
                            state_next = ssa_pkg::ST_DONE;
                        end
                    end
                end
            end

            ssa_pkg::ST_REL_PREV: begin
                mem.we         = 1'b1;
                mem.waddr      = prev_reg;
                mem.wdata.next = next_reg;
                if (in_pool(next_reg)) begin
                    mem.raddr  = next_reg;
                    state_next = ssa_pkg::ST_REL_NEXT;
                end else begin
                    state_next = ssa_pkg::ST_DONE;
                end
            end

            ssa_pkg::ST_REL_NEXT: begin
                mem.we         = 1'b1;
                mem.waddr      = next_reg;
                mem.wdata.prev = prev_reg;
                state_next     = ssa_pkg::ST_DONE;
            end

            ssa_pkg::ST_DONE: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    state_next = ssa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ssa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/session_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_slot_allocator
// pool of session slots with a lifo free list and per-owner limit
// ----------------------------------------------------------------------------
// Every slot lives in one entry of a single slot memory (in-use flag, owner,
// next and prev links); free slots chain as a lifo through the next links and
// taken slots form a doubly linked active list. After reset a clearing pass
// lays down the free chain 0,1,2,... during which no request is taken.
// Requests are handled one at a time. An allocate walks the active list one
// entry per cycle, at most SLOTS entries, to count the owner's slots; a
// release does a read-modify-write of its neighbors through the single write
// port. The result sits in an output register, so the next request is taken
// while it waits. max_per_owner is to be written by the user through the
// cfg channel while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module session_slot_allocator #(
    parameter int SLOTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] owner_id, [19:16] slot_index, [23:20] zero
    input  logic [ssa_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] action
    input  logic                              s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] status, [5:2] granted_slot, [7:6] zero
    output logic [ssa_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration: max_per_owner
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssa_pkg::CFG_W-1:0]         cfg_data
);

    localparam int ADDR_W = $clog2(SLOTS);

    logic [ssa_pkg::CFG_W-1:0]     max_per_owner_reg;
    logic                          m_tvalid_reg;
    logic [ssa_pkg::M_TDATA_W-1:0] m_tdata_reg;

    ssa_pkg::ssa_req_t     req;
    ssa_pkg::ssa_res_t     res;
    ssa_pkg::ssa_mem_req_t mem;
    ssa_pkg::ssa_entry_t   mem_rdata;
    logic [ssa_pkg::ENTRY_W-1:0] ram_rdata;
    logic                  res_ready;

    // unpack the request
    assign req.action = s_tuser;
    assign req.owner  = s_tdata[ssa_pkg::OWNER_W-1:0];
    assign req.slot   = s_tdata[ssa_pkg::OWNER_W +: ssa_pkg::SLOT_W];

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_per_owner_reg <= ssa_pkg::MAX_PER_OWNER_RST;
        end else if (cfg_valid) begin
            max_per_owner_reg <= cfg_data;
        end
    end

    // output register decouples the sequencer from the result consumer
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res.valid) begin
            m_tdata_reg <= {2'b00, res.slot, res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ssa_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (s_tvalid),
        .req_ready     (s_tready),
        .req           (req),
        .max_per_owner (max_per_owner_reg),
        .res           (res),
        .res_ready     (res_ready),
        .mem           (mem),
        .mem_rdata     (mem_rdata)
    );

    // slot memory, one entry per slot
    ssa_ram #(
        .WIDTH (ssa_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (mem.we),
        .waddr (mem.waddr[ADDR_W-1:0]),
        .wdata (mem.wdata),
        .raddr (mem.raddr[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign mem_rdata = ssa_pkg::ssa_entry_t'(ram_rdata);

endmodule

FILE: sv/ssa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_checker
// port-level checks of the session slot allocator
// ----------------------------------------------------------------------------
module ssa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ssa_pkg::M_TDATA_W-1:0] m_tdata
);

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // status is ok, limit or not active
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // failed requests grant slot zero
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ssa_pkg::STATUS_OK |-> m_tdata[5:2] == 4'd0)
        else $error("slot granted on failure");

endmodule

bind session_slot_allocator ssa_checker u_ssa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the session slot allocator
// ----------------------------------------------------------------------------
// A queue of requests is filled in phases by the stimulus process and played
// into the request channel by a bursty driver. A monitor keeps its own copy
// of the free list, the active list and the owner table. It works out the
// result of every accepted request and checks each returned result against
// the oldest outstanding one. Between phases the bench drains all results and
// then rewrites max_per_owner, covering zero, one, the sixteen-slot pool size
// and the largest field value.
// ----------------------------------------------------------------------------
module tb;
    import ssa_pkg::*;

    localparam int SLOTS      = 16;
    localparam int IDLE_GAP   = 32;   // longest allocate walk plus margin
    localparam int LONG_HOLD  = 200;  // receiver back-pressure stretch
    localparam int HOLD_AFTER = 150;  // requests accepted before the stretch

    // expected content of one result
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
    } grant_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // requests waiting to be offered, results waiting to arrive
    ssa_req_t request_q[$];
    grant_t   grant_q[$];

    // shadow of the allocator state
    logic [LINK_W-1:0]  link_nxt [SLOTS];
    logic [LINK_W-1:0]  link_prv [SLOTS];
    logic [OWNER_W-1:0] owner_of [SLOTS];
    logic               busy     [SLOTS];
    logic [LINK_W-1:0]  spare_top;
    logic [LINK_W-1:0]  used_top;
    logic [CFG_W-1:0]   owner_limit;

    int mismatches    = 0;
    int requests_seen = 0;
    int burst_left    = 0;
    int gap_left      = 0;

    always #5 aclk = ~aclk;

    session_slot_allocator #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // shadow update for one accepted request, returns its expected result
    function automatic grant_t allocate_or_release(input ssa_req_t req);
        grant_t g;
        int     idx;
        int     held;
        int     prv;
        int     nxt;
        g.status = STATUS_OK;
        g.slot   = '0;
        if (req.action == ACT_ALLOC) begin
            // count what this owner already holds along the active list
            held = 0;
            idx  = used_top;
            for (int n = 0; n < SLOTS && idx < SLOTS; n++) begin
                if (owner_of[idx] == req.owner) held++;
                idx = link_nxt[idx];
            end
            idx = spare_top;
            if (held >= int'(owner_limit) || idx >= SLOTS) begin
                g.status = STATUS_LIMIT;
            end else begin
                spare_top     = link_nxt[idx];
                link_nxt[idx] = used_top;
                link_prv[idx] = LINK_NONE;
                if (used_top < SLOTS) link_prv[used_top] = LINK_W'(idx);
                used_top      = LINK_W'(idx);
                owner_of[idx] = req.owner;
                busy[idx]     = 1'b1;
                g.slot        = SLOT_W'(idx);
            end
        end else begin
            idx = req.slot;
            if (idx >= SLOTS || !busy[idx]) begin
                g.status = STATUS_NOT_ACTIVE;
            end else begin
                // unlink from the active list, push onto the free list
                prv = link_prv[idx];
                nxt = link_nxt[idx];
                if (prv < SLOTS) link_nxt[prv] = LINK_W'(nxt);
                else used_top = LINK_W'(nxt);
                if (nxt < SLOTS) link_prv[nxt] = LINK_W'(prv);
                owner_of[idx] = '0;
                busy[idx]     = 1'b0;
                link_nxt[idx] = spare_top;
                link_prv[idx] = LINK_NONE;
                spare_top     = LINK_W'(idx);
            end
        end
        return g;
    endfunction

    // driver: bursts of requests with random gaps in between
    always @(posedge aclk) begin
        ssa_req_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (request_q.size() > 0) begin
                next_req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.action;
                s_tdata  <= {4'b0000, next_req.slot, next_req.owner};
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // a third of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern that picks a new mode at random whenever the
    // six-bit tick wraps, plus one long hold-off once enough requests have gone in
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   stall_mode = 0;
    logic [5:0] stall_tick = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && requests_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            stall_tick++;
            if (stall_tick == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_tready <= (stall_tick[1:0] == 2'b00);
                end
            endcase
        end
    end

    // monitor: check results first, then predict for the request taken at
    // the same edge, then follow register writes
    always @(posedge aclk) begin
        grant_t   want;
        ssa_req_t req;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing outstanding", m_tdata));
                end else begin
                    want = grant_q.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tdata[1:0], want.status));
                    if (m_tdata[5:2] !== want.slot)
                        report_mismatch($sformatf("granted_slot %0d, want %0d",
                                                  m_tdata[5:2], want.slot));
                end
            end
            if (s_tvalid && s_tready) begin
                req.action = s_tuser;
                req.owner  = s_tdata[15:0];
                req.slot   = s_tdata[19:16];
                grant_q.push_back(allocate_or_release(req));
                requests_seen <= requests_seen + 1;
            end
            if (cfg_valid && cfg_ready) owner_limit = cfg_data;
        end
    end

    task automatic queue_alloc(input logic [OWNER_W-1:0] owner);
        ssa_req_t r;
        r.action = ACT_ALLOC;
        r.owner  = owner;
        r.slot   = SLOT_W'($urandom);  // unused by allocate, still toggled
        request_q.push_back(r);
    endtask

    task automatic queue_release(input logic [SLOT_W-1:0] slot);
        ssa_req_t r;
        r.action = ACT_RELEASE;
        r.owner  = OWNER_W'($urandom);
        r.slot   = slot;
        request_q.push_back(r);
    endtask

    // random mix; most owners come from a small set so limits get hit
    task automatic queue_random(input int count, input int alloc_pct);
        logic [OWNER_W-1:0] regulars [4];
        regulars = '{16'h0000, 16'h00A5, 16'hFFFF, 16'h7F3C};
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                if ($urandom_range(0, 3) != 0) queue_alloc(regulars[$urandom_range(0, 3)]);
                else queue_alloc(OWNER_W'($urandom_range(0, 65535)));
            end else begin
                queue_release(SLOT_W'($urandom_range(0, SLOTS - 1)));
            end
        end
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_idle();
        do @(negedge aclk);
        while (request_q.size() != 0 || s_tvalid || grant_q.size() != 0);
        repeat (IDLE_GAP) @(negedge aclk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        // shadow starts in the post-reset state: free chain 0,1,2,...
        for (int i = 0; i < SLOTS; i++) begin
            link_nxt[i] = (i + 1 < SLOTS) ? LINK_W'(i + 1) : LINK_NONE;
            link_prv[i] = LINK_NONE;
            owner_of[i] = '0;
            busy[i]     = 1'b0;
        end
        spare_top   = '0;
        used_top    = LINK_NONE;
        owner_limit = MAX_PER_OWNER_RST;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default limit of four: owner zero fills up and hits the limit
        repeat (5) queue_alloc(16'h0000);
        queue_alloc(16'hFFFF);
        queue_release(4'd15);      // slot never taken
        queue_release(4'd1);       // middle of the active list
        queue_release(4'd4);       // head of the active list
        queue_release(4'd0);       // tail of the active list
        queue_release(4'd0);       // same slot again, already free
        queue_alloc(16'hA5A5);     // reuses the slot freed last
        wait_idle();

        // limit of zero refuses everything
        set_limit(5'd0);
        queue_alloc(16'h0000);
        wait_idle();

        // largest limit: drain the pool until it runs empty
        set_limit(5'd31);
        repeat (14) queue_alloc(16'h1234);
        wait_idle();

        // owner at its limit while the pool is empty as well
        set_limit(5'd13);
        queue_alloc(16'h1234);
        wait_idle();

        set_limit(5'd1);
        queue_random(78, 60);
        wait_idle();

        // long receiver hold-off lands in this phase
        set_limit(5'd16);
        queue_random(78, 70);
        wait_idle();

        set_limit(5'd2);
        queue_random(78, 50);
        wait_idle();

        set_limit(CFG_W'($urandom_range(1, 16)));
        queue_random(78, 65);
        wait_idle();

        set_limit(5'd31);
        queue_random(78, 75);
        wait_idle();

        set_limit(MAX_PER_OWNER_RST);
        queue_random(78, 40);
        wait_idle();

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/ssa_pkg.sv
sv/ssa_ram.sv
sv/ssa_seq.sv
sv/session_slot_allocator.sv
sv/ssa_checker.sv
tb/sv/tb.sv
